[hw/rtl/tkrs_pkg.sv]
// Shared types, constants and the record comparison for the three-key record sorter.
// Used by tkrs_cell and triple_key_record_sorter_unit; depends on nothing.
package tkrs_pkg;

    localparam int KEY_W           = 32;
    localparam int MAX_RECORDS_DEF = 64;

    typedef struct packed {
        logic [KEY_W-1:0] primary;
        logic [KEY_W-1:0] secondary;
        logic [KEY_W-1:0] tertiary;
    } rec_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    // Inverting each sign bit turns the signed lexicographic order into one unsigned compare.
    function automatic logic rec_less(rec_t a, rec_t b);
        logic [3*KEY_W-1:0] x;
        logic [3*KEY_W-1:0] y;
        x = {~a.primary[KEY_W-1], a.primary[KEY_W-2:0],
             ~a.secondary[KEY_W-1], a.secondary[KEY_W-2:0],
             ~a.tertiary[KEY_W-1], a.tertiary[KEY_W-2:0]};
        y = {~b.primary[KEY_W-1], b.primary[KEY_W-2:0],
             ~b.secondary[KEY_W-1], b.secondary[KEY_W-2:0],
             ~b.tertiary[KEY_W-1], b.tertiary[KEY_W-2:0]};
        return x < y;
    endfunction

endpackage

[hw/rtl/tkrs_cell.sv]
// One cell of the insertion chain: holds a single record and its valid bit.
// Depends on tkrs_pkg.
module tkrs_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tkrs_pkg::cell_ctrl_t ctrl,
    input  tkrs_pkg::rec_t     new_rec,
    input  tkrs_pkg::rec_t     left_rec,
    input  logic               left_valid,
    input  logic               left_ins,
    input  tkrs_pkg::rec_t     right_rec,
    input  logic               right_valid,
    output tkrs_pkg::rec_t     own_rec,
    output logic               own_valid,
    output logic               ins_here
);
    import tkrs_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;
    logic valid_reg;
    logic valid_next;

    // An empty cell sorts after every record, so insertion points form a suffix of the chain.
    assign ins_here = !valid_reg || rec_less(new_rec, rec_reg);

    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            rec_next   = right_rec;
            valid_next = right_valid;
        end
        else if (ctrl.insert && ins_here)
        begin
            if (left_ins)
            begin
                rec_next   = left_rec;
                valid_next = left_valid;
            end
            else
            begin
                rec_next   = new_rec;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign own_rec   = rec_reg;
    assign own_valid = valid_reg;

endmodule

[hw/rtl/triple_key_record_sorter_unit.sv]
// Each accepted item is inserted into a chain of MAX_RECORDS cells kept in ascending
// order of primary, secondary and tertiary key, all signed. The item marked batch_end
// starts the drain: no item is accepted until every stored record has left, while the
// chain shifts one result per cycle into the output register, unless that register is
// full and out_ready is low. Records arriving at a full chain are dropped and
// overflow_seen is raised on every result of that batch. There is no clearing pass.
// Depends on tkrs_pkg and tkrs_cell.
module triple_key_record_sorter_unit #(
    parameter int MAX_RECORDS = tkrs_pkg::MAX_RECORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [tkrs_pkg::KEY_W-1:0] key_primary,
    input  logic signed [tkrs_pkg::KEY_W-1:0] key_secondary,
    input  logic signed [tkrs_pkg::KEY_W-1:0] key_tertiary,
    input  logic                           batch_end,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [tkrs_pkg::KEY_W-1:0] sorted_primary,
    output logic signed [tkrs_pkg::KEY_W-1:0] sorted_secondary,
    output logic signed [tkrs_pkg::KEY_W-1:0] sorted_tertiary,
    output logic                           final_record,
    output logic                           overflow_seen
);
    import tkrs_pkg::*;

    typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

    state_t state_reg;
    logic   ovf_reg;
    logic   out_valid_reg;
    rec_t   out_rec_reg;
    logic   final_reg;
    logic   ovf_out_reg;

    rec_t                   new_rec;
    rec_t                   cell_rec [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] cell_valid;
    logic [MAX_RECORDS-1:0] cell_ins;
    cell_ctrl_t             ctrl;
    logic                   in_accept;
    logic                   full;
    logic                   load_out;

    assign new_rec   = '{primary: key_primary, secondary: key_secondary,
                         tertiary: key_tertiary};
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_accept = in_valid && in_ready;
    assign full      = cell_valid[MAX_RECORDS-1];
    assign load_out  = (state_reg == ST_DRAIN) && (!out_valid_reg || out_ready);

    assign ctrl.insert = in_accept && !full;
    assign ctrl.shift  = load_out;

    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        rec_t left_rec;
        logic left_valid;
        logic left_ins;
        rec_t right_rec;
        logic right_valid;

        if (i == 0)
        begin : g_first
            assign left_rec   = '0;
            assign left_valid = 1'b0;
            assign left_ins   = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_rec   = cell_rec[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_ins   = cell_ins[i-1];
        end

        if (i == MAX_RECORDS - 1)
        begin : g_last
            assign right_rec   = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_rec   = cell_rec[i+1];
            assign right_valid = cell_valid[i+1];
        end

        tkrs_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_rec     (new_rec),
            .left_rec    (left_rec),
            .left_valid  (left_valid),
            .left_ins    (left_ins),
            .right_rec   (right_rec),
            .right_valid (right_valid),
            .own_rec     (cell_rec[i]),
            .own_valid   (cell_valid[i]),
            .ins_here    (cell_ins[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_rec_reg   <= '0;
            final_reg     <= 1'b0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_accept)
                    begin
                        if (full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (batch_end)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        out_rec_reg   <= cell_rec[0];
                        final_reg     <= !cell_valid[1];
                        ovf_out_reg   <= ovf_reg;
                        if (!cell_valid[1])
                        begin
                            state_reg <= ST_LOAD;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign sorted_primary   = out_rec_reg.primary;
    assign sorted_secondary = out_rec_reg.secondary;
    assign sorted_tertiary  = out_rec_reg.tertiary;
    assign final_record     = final_reg;
    assign overflow_seen    = ovf_out_reg;

    logic [MAX_RECORDS:0] occ_plus_one;
    assign occ_plus_one = {1'b0, cell_valid} + {{MAX_RECORDS{1'b0}}, 1'b1};

    // Occupied cells always form an unbroken run starting at the head of the chain.
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(occ_plus_one))
        else $error("chain occupancy is not a prefix");

    // The drain never runs on an empty chain.
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain with empty head cell");

    // A batch end item closes the input until the batch has drained.
    a_batch_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && batch_end) |=> !in_ready)
        else $error("input still open after batch end");

    // The final result leaves the chain empty at the moment it is loaded.
    a_final_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !cell_valid[1]) |=> (cell_valid == '0))
        else $error("records left behind after final result");

endmodule
